[src/bmpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpe_pkg
// Shared types, codes and CORDIC helpers for the bicycle-model pose expansion.
// ----------------------------------------------------------------------------
package bmpe_pkg;

	localparam int CRD_ITERS = 31;
	localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
	localparam logic [63:0] TURN_Q64 = 64'h28BE_60DB_9391_054A;
	localparam logic [29:0] STEER_MAX = 30'h2000_0000;

	localparam logic [30:0] STEP_RESET = 31'd65536;
	localparam logic [29:0] STEER_RESET = 30'd357913941;
	localparam logic [22:0] WB_RESET = 23'd176947;

	typedef enum logic [2:0] {
		DIR_LEFT_FWD   = 3'd0,
		DIR_FWD        = 3'd1,
		DIR_RIGHT_FWD  = 3'd2,
		DIR_RIGHT_BACK = 3'd3,
		DIR_BACK       = 3'd4,
		DIR_LEFT_BACK  = 3'd5
	} dir_t;

	typedef enum logic [1:0] {
		CFG_STEP  = 2'd0,
		CFG_STEER = 2'd1,
		CFG_WB    = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_LOAD,
		SEQ_TRIG,
		SEQ_TSET,
		SEQ_TDIV,
		SEQ_RSET,
		SEQ_RDIV,
		SEQ_BMUL,
		SEQ_WSET,
		SEQ_WDIV,
		SEQ_WEND
	} seq_t;

	typedef struct packed {
		logic               flip;
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
	} crd_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] nh;
		logic [2:0]  dir;
		logic        curved;
		logic [61:0] a;
	} side_t;

	function automatic logic [29:0] atan_val(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'h20000000;
			5'd1:  v = 30'h12E4051E;
			5'd2:  v = 30'h09FB385B;
			5'd3:  v = 30'h051111D4;
			5'd4:  v = 30'h028B0D43;
			5'd5:  v = 30'h0145D7E1;
			5'd6:  v = 30'h00A2F61E;
			5'd7:  v = 30'h00517C55;
			5'd8:  v = 30'h0028BE53;
			5'd9:  v = 30'h00145F2F;
			5'd10: v = 30'h000A2F98;
			5'd11: v = 30'h000517CC;
			5'd12: v = 30'h00028BE6;
			5'd13: v = 30'h000145F3;
			5'd14: v = 30'h0000A2FA;
			5'd15: v = 30'h0000517D;
			5'd16: v = 30'h000028BE;
			5'd17: v = 30'h0000145F;
			5'd18: v = 30'h00000A30;
			5'd19: v = 30'h00000518;
			5'd20: v = 30'h0000028C;
			5'd21: v = 30'h00000146;
			5'd22: v = 30'h000000A3;
			5'd23: v = 30'h00000051;
			5'd24: v = 30'h00000029;
			5'd25: v = 30'h00000014;
			5'd26: v = 30'h0000000A;
			5'd27: v = 30'h00000005;
			5'd28: v = 30'h00000003;
			5'd29: v = 30'h00000001;
			5'd30: v = 30'h00000001;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Fold the angle into [-90, 90) degrees; the results are negated at the end.
	function automatic crd_t crd_init(input logic [31:0] ang);
		crd_t c;
		logic [31:0] q;
		logic [31:0] a2;
		q = ang + 32'h4000_0000;
		a2 = q[31] ? (ang ^ 32'h8000_0000) : ang;
		c.flip = q[31];
		c.x = CORDIC_GAIN_INV;
		c.y = '0;
		c.z = 33'(signed'(a2));
		return c;
	endfunction

	function automatic crd_t crd_step(input crd_t c, input logic [4:0] i);
		crd_t r;
		logic signed [33:0] tx;
		logic signed [33:0] ty;
		tx = c.y >>> i;
		ty = c.x >>> i;
		r = c;
		if (!c.z[32]) begin
			r.x = c.x - tx;
			r.y = c.y + ty;
			r.z = c.z - 33'(atan_val(i));
		end else begin
			r.x = c.x + tx;
			r.y = c.y - ty;
			r.z = c.z + 33'(atan_val(i));
		end
		return r;
	endfunction

	function automatic logic signed [33:0] crd_cos(input crd_t c);
		return c.flip ? -c.x : c.x;
	endfunction

	function automatic logic signed [33:0] crd_sin(input crd_t c);
		return c.flip ? -c.y : c.y;
	endfunction

endpackage

[src/bicycle_model_pose_expansion_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicycle_model_pose_expansion_unit
// Successor pose of a kinematic bicycle model for one of six motion primitives.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              beat
//  pose in   in         start & !busy          pos_x, pos_y, heading, direction
//  pose out  out        done (one cycle)       new_x, new_y, new_heading, new_direction
//  config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
//  One pose is taken every cycle while busy is low.
//  A pose passes the entry stage, the 31-stage CORDIC pipeline, and the operand,
//  product, floor and output stages. After reset and after every configuration
//  write, busy stays high while one shared iterative divider and CORDIC derive
//  tan, turn angle and radius. Results cannot be held off, so the pipeline never stalls.
module bicycle_model_pose_expansion_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [31:0]        heading,
	input  logic [2:0]         direction,
	output logic               done,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic [31:0]        new_heading,
	output logic [2:0]         new_direction,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);
	import bmpe_pkg::*;

	// Configuration and derived constants.
	logic [30:0] step_q;
	logic [29:0] steer_q;
	logic [22:0] wb_q;
	logic [31:0] tanq_q;
	logic [31:0] dba_q;
	logic [53:0] rmag_q;

	seq_t state_q, state_d;
	crd_t crd_q;
	logic [5:0] cnt_q;
	logic [63:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [127:0] acc_q;

	logic cfg_wr;
	logic [29:0] steer_eff;
	logic [22:0] wb_eff;
	logic signed [33:0] ss_c, cs_c;
	logic [32:0] div_t;
	logic div_ge;
	logic [31:0] rem_n;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid & cfg_ready;
	assign steer_eff = (steer_q > STEER_MAX) ? STEER_MAX : steer_q;
	assign wb_eff = (wb_q == '0) ? 23'd1 : wb_q;
	assign ss_c = crd_sin(crd_q);
	assign cs_c = crd_cos(crd_q);

	assign div_t = {rem_q, num_q[63]};
	assign div_ge = div_t >= {1'b0, den_q};
	assign rem_n = div_ge ? 32'(div_t - {1'b0, den_q}) : div_t[31:0];

	assign mul_a = cnt_q[0] ? num_q[63:32] : num_q[31:0];
	assign mul_b = cnt_q[1] ? TURN_Q64[63:32] : TURN_Q64[31:0];
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			steer_q <= STEER_RESET;
			wb_q <= WB_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_STEP:  step_q <= cfg_data;
				CFG_STEER: steer_q <= cfg_data[29:0];
				CFG_WB:    wb_q <= cfg_data[22:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: state_d = SEQ_IDLE;
			SEQ_LOAD: state_d = SEQ_TRIG;
			SEQ_TRIG: if (cnt_q == 6'(CRD_ITERS - 1)) state_d = SEQ_TSET;
			SEQ_TSET: begin
				if (steer_eff == '0 || cs_c <= 0) state_d = SEQ_IDLE;
				else state_d = SEQ_TDIV;
			end
			SEQ_TDIV: if (cnt_q == 6'd63) state_d = SEQ_RSET;
			SEQ_RSET: begin
				if (num_q[31:0] == '0) state_d = SEQ_IDLE;
				else state_d = SEQ_RDIV;
			end
			SEQ_RDIV: if (cnt_q == 6'd63) state_d = SEQ_BMUL;
			SEQ_BMUL: if (cnt_q == 6'd3) state_d = SEQ_WSET;
			SEQ_WSET: state_d = SEQ_WDIV;
			SEQ_WDIV: if (cnt_q == 6'd63) state_d = SEQ_WEND;
			SEQ_WEND: state_d = SEQ_IDLE;
			default:  state_d = SEQ_IDLE;
		endcase
		if (cfg_wr) state_d = SEQ_LOAD;
	end

	assign busy = (state_q != SEQ_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tanq_q <= '0;
			dba_q <= '0;
			rmag_q <= '0;
			cnt_q <= '0;
			crd_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			acc_q <= '0;
		end else begin
			case (state_q)
				SEQ_LOAD: begin
					crd_q <= crd_init({2'b00, steer_eff});
					cnt_q <= '0;
				end
				SEQ_TRIG: begin
					crd_q <= crd_step(crd_q, cnt_q[4:0]);
					cnt_q <= (cnt_q == 6'(CRD_ITERS - 1)) ? '0 : cnt_q + 6'd1;
				end
				SEQ_TSET: begin
					tanq_q <= '0;
					num_q <= ss_c[33] ? '0 : (64'(ss_c[32:0]) << 30);
					den_q <= cs_c[31:0];
					rem_q <= '0;
					cnt_q <= '0;
				end
				SEQ_TDIV, SEQ_RDIV, SEQ_WDIV: begin
					num_q <= {num_q[62:0], div_ge};
					rem_q <= rem_n;
					cnt_q <= cnt_q + 6'd1;
					acc_q <= '0;
				end
				SEQ_RSET: begin
					tanq_q <= num_q[31:0];
					num_q <= step_q * num_q[31:0];
					den_q <= 32'(wb_eff);
					rem_q <= '0;
					cnt_q <= '0;
				end
				SEQ_BMUL: begin
					case (2'(cnt_q[0]) + 2'(cnt_q[1]))
						2'd0:    acc_q <= acc_q + 128'(mul_p);
						2'd1:    acc_q <= acc_q + (128'(mul_p) << 32);
						default: acc_q <= acc_q + (128'(mul_p) << 64);
					endcase
					cnt_q <= (cnt_q == 6'd3) ? '0 : cnt_q + 6'd1;
				end
				SEQ_WSET: begin
					dba_q <= acc_q[93:62];
					num_q <= {11'b0, wb_eff, 30'b0};
					den_q <= tanq_q;
					rem_q <= '0;
					cnt_q <= '0;
				end
				SEQ_WEND: rmag_q <= num_q[53:0];
				default: ;
			endcase
		end
	end

	// Entry stage: decode the primitive and pick the multiplier operand.
	logic svp, svn, spp, spn;
	logic in_fire;
	logic curved_c;
	logic [61:0] dsg_c, rsg_c;
	logic [31:0] nh_c;

	assign in_fire = start & ~busy;

	always_comb begin
		svp = 1'b0;
		svn = 1'b0;
		spp = 1'b0;
		spn = 1'b0;
		case (direction)
			DIR_LEFT_FWD:   begin svp = 1'b1; spp = 1'b1; end
			DIR_FWD:        svp = 1'b1;
			DIR_RIGHT_FWD:  begin svp = 1'b1; spn = 1'b1; end
			DIR_RIGHT_BACK: begin svn = 1'b1; spn = 1'b1; end
			DIR_BACK:       svn = 1'b1;
			DIR_LEFT_BACK:  begin svn = 1'b1; spp = 1'b1; end
			default:        ;
		endcase
	end

	assign curved_c = (spp | spn) && (tanq_q != '0);
	assign dsg_c = svp ? 62'(step_q) : (svn ? -62'(step_q) : '0);
	assign rsg_c = spp ? 62'(rmag_q) : (spn ? -62'(rmag_q) : '0);
	assign nh_c = !curved_c ? heading :
		(((svp & spp) | (svn & spn)) ? heading + dba_q : heading - dba_q);

	logic v_s1;
	logic [31:0] h_s1;
	side_t side_s1;

	always_ff @(posedge clk) begin
		h_s1 <= heading;
		side_s1.x <= pos_x;
		side_s1.y <= pos_y;
		side_s1.nh <= nh_c;
		side_s1.dir <= direction;
		side_s1.curved <= curved_c;
		side_s1.a <= curved_c ? rsg_c : dsg_c;
	end

	// Stage 2 is the CORDIC run: entry k holds the vectors after k micro-rotations.
	logic [CRD_ITERS:0] v_s2;
	crd_t hcor_s2 [CRD_ITERS+1];
	crd_t ncor_s2 [CRD_ITERS+1];
	side_t side_s2 [CRD_ITERS+1];

	always_ff @(posedge clk) begin
		hcor_s2[0] <= crd_init(h_s1);
		ncor_s2[0] <= crd_init(side_s1.nh);
		side_s2[0] <= side_s1;
	end

	for (genvar k = 0; k < CRD_ITERS; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			hcor_s2[k+1] <= crd_step(hcor_s2[k], 5'(k));
			ncor_s2[k+1] <= crd_step(ncor_s2[k], 5'(k));
			side_s2[k+1] <= side_s2[k];
		end
	end

	// Stage 3: operands. Straight moves use the heading itself, curves the chord.
	logic signed [33:0] s0_c, c0_c, s1_c, c1_c;
	logic signed [34:0] dsx_c, dsy_c;
	side_t side_s3;
	logic [61:0] bx_s3, by_s3;

	assign s0_c = crd_sin(hcor_s2[CRD_ITERS]);
	assign c0_c = crd_cos(hcor_s2[CRD_ITERS]);
	assign s1_c = crd_sin(ncor_s2[CRD_ITERS]);
	assign c1_c = crd_cos(ncor_s2[CRD_ITERS]);
	assign dsx_c = 35'(s1_c) - 35'(s0_c);
	assign dsy_c = 35'(c0_c) - 35'(c1_c);

	always_ff @(posedge clk) begin
		side_s3 <= side_s2[CRD_ITERS];
		bx_s3 <= side_s2[CRD_ITERS].curved ? 62'(dsx_c) : 62'(c0_c);
		by_s3 <= side_s2[CRD_ITERS].curved ? 62'(dsy_c) : 62'(s0_c);
	end

	// Stage 4: product modulo 2^62 from 31-bit halves; the high-by-high term drops.
	side_t side_s4;
	logic [61:0] pllx_s4, plly_s4;
	logic [30:0] pmx_s4, pmy_s4;

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		pllx_s4 <= 62'(side_s3.a[30:0]) * 62'(bx_s3[30:0]);
		plly_s4 <= 62'(side_s3.a[30:0]) * 62'(by_s3[30:0]);
		pmx_s4 <= 31'(side_s3.a[61:31] * bx_s3[30:0]) + 31'(side_s3.a[30:0] * bx_s3[61:31]);
		pmy_s4 <= 31'(side_s3.a[61:31] * by_s3[30:0]) + 31'(side_s3.a[30:0] * by_s3[61:31]);
	end

	// Stage 5: floor by 2^30 and keep 32 bits.
	logic [61:0] sumx_c, sumy_c;
	side_t side_s5;
	logic [31:0] dx_s5, dy_s5;

	assign sumx_c = pllx_s4 + {pmx_s4, 31'b0};
	assign sumy_c = plly_s4 + {pmy_s4, 31'b0};

	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		dx_s5 <= sumx_c[61:30];
		dy_s5 <= sumy_c[61:30];
	end

	always_ff @(posedge clk) begin
		new_x <= signed'(side_s5.x + dx_s5);
		new_y <= signed'(side_s5.y + dy_s5);
		new_heading <= side_s5.nh;
		new_direction <= side_s5.dir;
	end

	logic v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= '0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			v_s2 <= {v_s2[CRD_ITERS-1:0], v_s1};
			v_s3 <= v_s2[CRD_ITERS];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			done <= v_s5;
		end
	end

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> busy)
		else $error("busy not raised after a configuration write");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |=> done)
		else $error("result strobe lost at the output stage");

	a_curve_needs_tan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && side_s1.curved) |-> ($past(tanq_q) != '0))
		else $error("curved move taken with a zero tangent");

	a_null_code: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (side_s1.dir == 3'd6 || side_s1.dir == 3'd7))
			|-> (side_s1.a == '0 && !side_s1.curved))
		else $error("unused direction code produced motion");

endmodule
